/* design/dqr_pkg.sv */
`default_nettype none
package dqr_pkg;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    localparam logic [ACTION_W-1:0] ACT_PUSH_HEAD = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_TAIL = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_HEAD  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_TAIL  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REVERSE   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] popped_value;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        entry_count;
    } t_out_item;

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take;   // request accepted this cycle
        logic load;   // move finished result into output register
    } t_cmd;

endpackage
`default_nettype wire

/* design/dqr_ctrl.sv */
`default_nettype none
module dqr_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output dqr_pkg::t_cmd    o_cmd
);
    import dqr_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd.take  = 1'b0;
        o_cmd.load  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

/* design/dqr_datapath.sv */
`default_nettype none
module dqr_datapath #(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dqr_pkg::t_cmd      i_cmd,
    input  wire dqr_pkg::t_in_item  i_in_item,
    output dqr_pkg::t_out_item      o_out_item
);
    import dqr_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
    localparam logic [CW:0]   DEPTH_S  = (CW+1)'(QUEUE_DEPTH);

    logic signed [VALUE_W-1:0] mem [QUEUE_DEPTH];

    logic [IW-1:0]       r_front, n_front;
    logic [CW-1:0]       r_count, n_count;
    logic                r_rev, n_rev;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [CW-1:0]       r_res_count;
    logic                r_pop_ok, n_pop_ok;
    logic signed [VALUE_W-1:0] r_rd_data;
    t_out_item           r_out;

    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic          is_push, is_pop, at_front;
    logic [CW:0]   sum_end, sum_last, idx_end, idx_last;
    logic [CW+COUNT_W-1:0] cnt_ext;

    always_comb begin
        is_push  = (i_in_item.action == ACT_PUSH_HEAD) || (i_in_item.action == ACT_PUSH_TAIL);
        is_pop   = (i_in_item.action == ACT_POP_HEAD) || (i_in_item.action == ACT_POP_TAIL);
        // head is the physical front unless reversed
        at_front = ((i_in_item.action == ACT_PUSH_HEAD) || (i_in_item.action == ACT_POP_HEAD))
                   ^ r_rev;

        // physical slots one past the back and at the back
        sum_end  = (CW+1)'(r_front) + (CW+1)'(r_count);
        sum_last = sum_end - (CW+1)'(1);
        idx_end  = (sum_end >= DEPTH_S) ? sum_end - DEPTH_S : sum_end;
        idx_last = (sum_last >= DEPTH_S) ? sum_last - DEPTH_S : sum_last;

        n_front  = r_front;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = ST_DONE;
        n_pop_ok = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        wr_addr  = idx_end[IW-1:0];
        rd_addr  = idx_last[IW-1:0];

        if (is_push) begin
            if (r_count == FULL_CNT) begin
                n_status = ST_FULL;
            end else begin
                wr_en   = i_cmd.take;
                n_count = r_count + CW'(1);
                if (at_front) begin
                    n_front = (r_front == '0) ? LAST_IDX : r_front - IW'(1);
                    wr_addr = n_front;
                end
            end
        end else if (is_pop) begin
            if (r_count == '0) begin
                n_status = ST_EMPTY;
            end else begin
                rd_en    = i_cmd.take;
                n_pop_ok = 1'b1;
                n_count  = r_count - CW'(1);
                if (at_front) begin
                    rd_addr = r_front;
                    n_front = (r_front == LAST_IDX) ? '0 : r_front + IW'(1);
                end
            end
        end else if (i_in_item.action == ACT_REVERSE) begin
            n_rev = !r_rev;
        end

        cnt_ext = (CW+COUNT_W)'(r_res_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_cmd.take) begin
            r_front <= n_front;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_in_item.push_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_status    <= n_status;
            r_pop_ok    <= n_pop_ok;
            r_res_count <= n_count;
        end
        if (i_cmd.load) begin
            r_out.popped_value <= r_pop_ok ? r_rd_data : '0;
            r_out.status       <= r_status;
            r_out.entry_count  <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign o_out_item = r_out;

endmodule
`default_nettype wire

/* design/double_ended_queue_with_reverse_core.sv */
`default_nettype none
// Channel  Direction  Handshake               Payload
// in       input      i_in_valid/o_in_ready   i_in_item  (action, push_value)
// out      output     o_out_valid/i_out_ready o_out_item (popped_value, status, entry_count)
//
// On each request the accept edge updates pointers and count and writes or
// reads the ring memory; the load state then moves the result into the
// output register. A new request is taken while a result waits there.
// A stalled output holds the load state until the register frees up.
// Synchronous active-low reset clears pointers, count and reverse flag; the
// memory is not cleared.
module double_ended_queue_with_reverse_core #(
    parameter int QUEUE_DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire dqr_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output dqr_pkg::t_out_item      o_out_item
);
    import dqr_pkg::*;

    t_cmd cmd;

    dqr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    dqr_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule
`default_nettype wire
